/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file bfwbr_chk.sv.
// Needs clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled in reset
`define BFW_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Condition that must never hold
`define BFW_ASSERT_NEVER(name, cond) \
  `BFW_ASSERT(name, !(cond))

`endif

/* rtl/core/bfwbr_pkg.sv */
// Package for the broadcast FIFO with buffer release.
// Types, codes and defaults used by the controller, datapath, top level, checker and testbench.
package bfwbr_pkg;

  localparam int unsigned CONSUMERS_DEF     = 8;
  localparam int unsigned RING_DEPTH_DEF    = 16;
  localparam int unsigned TABLE_ENTRIES_DEF = 32;
  localparam int unsigned CNT_W             = 4;
  localparam int unsigned NUM_W             = 5;
  localparam int unsigned MASK_W            = 8;

  typedef enum logic [1:0] {
    OP_PUT = 2'd0,
    OP_POP = 2'd1,
    OP_REL = 2'd2,
    OP_NOP = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DUP      = 3'd4
  } status_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic eval;
    logic bcast;
    logic pop;
    logic popw;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic go_bcast;
    logic bcast_end;
    logic pop_hit;
  } sts_t;

endpackage

/* rtl/core/bfwbr_ctrl.sv */
// Controller of the broadcast FIFO with buffer release.
// Sequences table scan, broadcast, pop and result; uses bfwbr_pkg.
module bfwbr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bfwbr_pkg::sts_t   sts_i,
  output bfwbr_pkg::cmd_t   cmd_o
);
  import bfwbr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_EVAL   = 7'b0000100,
    S_BCAST  = 7'b0001000,
    S_POP    = 7'b0010000,
    S_POPW   = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   emit_ok;

  assign emit_ok    = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (opcode_e'(opcode_i))
            OP_PUT, OP_REL: state_d = S_SCAN;
            OP_POP:         state_d = S_POP;
            default:        state_d = S_RESULT;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.go_bcast ? S_BCAST : S_RESULT;
      end
      S_BCAST: begin
        cmd_o.bcast = 1'b1;
        if (sts_i.bcast_end) state_d = S_RESULT;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = sts_i.pop_hit ? S_POPW : S_RESULT;
      end
      S_POPW: begin
        cmd_o.popw = 1'b1;
        state_d    = S_RESULT;
      end
      S_RESULT: begin
        if (emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/bfwbr_dp.sv */
// Datapath of the broadcast FIFO with buffer release.
// Holds rings, pointers, release table and result registers; uses bfwbr_pkg.
module bfwbr_dp #(
  parameter int unsigned CONSUMERS     = bfwbr_pkg::CONSUMERS_DEF,
  parameter int unsigned RING_DEPTH    = bfwbr_pkg::RING_DEPTH_DEF,
  parameter int unsigned TABLE_ENTRIES = bfwbr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfwbr_pkg::cmd_t               cmd_i,
  output bfwbr_pkg::sts_t               sts_o,
  input  logic                          cfg_we_i,
  input  logic [3:0]                    cfg_data_i,
  input  logic [1:0]                    opcode_i,
  input  logic [2:0]                    consumer_i,
  input  logic [31:0]                   buffer_handle_i,
  input  logic [31:0]                   payload_i,
  output logic [2:0]                    status_o,
  output logic [31:0]                   popped_handle_o,
  output logic [31:0]                   popped_payload_o,
  output logic [bfwbr_pkg::MASK_W-1:0]  dropped_mask_o,
  output logic                          freed_o,
  output logic [31:0]                   freed_handle_o
);
  import bfwbr_pkg::*;

  localparam int unsigned TW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CIW = (CONSUMERS > 1) ? $clog2(CONSUMERS) : 1;
  localparam int unsigned CNW = $clog2(CONSUMERS + 1);
  localparam int unsigned PW  = $clog2(RING_DEPTH);
  localparam int unsigned AW  = (CONSUMERS * RING_DEPTH > 1) ?
                                $clog2(CONSUMERS * RING_DEPTH) : 1;
  localparam int unsigned MD  = CONSUMERS * RING_DEPTH;

  logic [3:0]        cc_q;
  logic [NUM_W-1:0]  num_act;

  logic [1:0]        op_q;
  logic [2:0]        cons_q;
  logic [31:0]       hnd_q, pay_q;

  logic [TW-1:0]     scan_idx_q, hit_idx_q, free_idx_q, rel_idx;
  logic              hit_q, free_found_q, hit_now, scan_last;
  logic [CNW-1:0]    cidx_q;
  logic [CIW-1:0]    bi, pi;

  logic                  tbl_valid_q [TABLE_ENTRIES];
  logic [CNT_W-1:0]      tbl_cnt_q   [TABLE_ENTRIES];
  logic [31:0]           tbl_hnd_q   [TABLE_ENTRIES];

  logic [PW-1:0]     rp_q [CONSUMERS];
  logic [PW-1:0]     wp_q [CONSUMERS];
  logic [63:0]       ring_mem [MD];
  logic [63:0]       rdata_q;

  logic [CNT_W-1:0]  rel_cnt;
  logic              rel_free, bend, bfull, pop_hit;
  logic [PW-1:0]     bwp_next, prp_next;
  logic [AW-1:0]     waddr, raddr;

  logic [2:0]        res_status_q;
  logic [31:0]       res_ph_q, res_pp_q, res_fh_q;
  logic [MASK_W-1:0] res_mask_q;
  logic              res_freed_q;

  assign num_act = (32'(cc_q) > CONSUMERS) ? NUM_W'(CONSUMERS) : NUM_W'(cc_q);

  assign hit_now   = tbl_valid_q[scan_idx_q] && (tbl_hnd_q[scan_idx_q] == hnd_q);
  assign scan_last = (scan_idx_q == TW'(TABLE_ENTRIES - 1));

  assign rel_idx  = (opcode_e'(op_q) == OP_PUT) ? free_idx_q : hit_idx_q;
  assign rel_cnt  = tbl_cnt_q[rel_idx] + CNT_W'(1);
  assign rel_free = ({1'b0, rel_cnt} >= num_act) || (rel_cnt == '0);

  assign bi       = cidx_q[CIW-1:0];
  assign bend     = (32'(cidx_q) >= 32'(num_act));
  assign bwp_next = (wp_q[bi] == PW'(RING_DEPTH - 1)) ? '0 : wp_q[bi] + PW'(1);
  assign bfull    = (bwp_next == rp_q[bi]);
  assign waddr    = AW'(bi) * AW'(RING_DEPTH) + AW'(wp_q[bi]);

  assign pi       = CIW'(cons_q);
  assign pop_hit  = (32'(cons_q) < CONSUMERS) && (rp_q[pi] != wp_q[pi]);
  assign prp_next = (rp_q[pi] == PW'(RING_DEPTH - 1)) ? '0 : rp_q[pi] + PW'(1);
  assign raddr    = AW'(pi) * AW'(RING_DEPTH) + AW'(rp_q[pi]);

  assign sts_o.scan_end  = hit_now || scan_last;
  assign sts_o.go_bcast  = (opcode_e'(op_q) == OP_PUT) && !hit_q && free_found_q;
  assign sts_o.bcast_end = bend;
  assign sts_o.pop_hit   = pop_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= 4'd1;
    end else if (cfg_we_i) begin
      cc_q <= cfg_data_i;
    end
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      cidx_q       <= '0;
    end else if (cmd_i.load) begin
      scan_idx_q   <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      cidx_q       <= '0;
    end else begin
      if (cmd_i.scan) begin
        if (hit_now) hit_q <= 1'b1;
        if (!tbl_valid_q[scan_idx_q] && !free_found_q) free_found_q <= 1'b1;
        if (!scan_last) scan_idx_q <= scan_idx_q + TW'(1);
      end
      if (cmd_i.bcast && !bend) cidx_q <= cidx_q + CNW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      cons_q <= consumer_i;
      hnd_q  <= buffer_handle_i;
      pay_q  <= payload_i;
    end
    if (cmd_i.scan) begin
      if (hit_now) hit_idx_q <= scan_idx_q;
      if (!tbl_valid_q[scan_idx_q] && !free_found_q) free_idx_q <= scan_idx_q;
    end
  end

  // release table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_valid_q[i] <= 1'b0;
        tbl_cnt_q[i]   <= '0;
      end
    end else if (cmd_i.eval) begin
      if (sts_o.go_bcast) begin
        tbl_valid_q[free_idx_q] <= 1'b1;
        tbl_cnt_q[free_idx_q]   <= '0;
      end else if (opcode_e'(op_q) == OP_REL && hit_q) begin
        tbl_valid_q[rel_idx] <= !rel_free;
        tbl_cnt_q[rel_idx]   <= rel_free ? '0 : rel_cnt;
      end
    end else if (cmd_i.bcast && !bend && bfull && tbl_valid_q[rel_idx]) begin
      tbl_valid_q[rel_idx] <= !rel_free;
      tbl_cnt_q[rel_idx]   <= rel_free ? '0 : rel_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && sts_o.go_bcast) tbl_hnd_q[free_idx_q] <= hnd_q;
  end

  // ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CONSUMERS; c++) begin
        rp_q[c] <= '0;
        wp_q[c] <= '0;
      end
    end else begin
      if (cmd_i.bcast && !bend && !bfull) wp_q[bi] <= bwp_next;
      if (cmd_i.pop && pop_hit) rp_q[pi] <= prp_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bcast && !bend && !bfull) ring_mem[waddr] <= {pay_q, hnd_q};
    if (cmd_i.pop && pop_hit) rdata_q <= ring_mem[raddr];
  end

  // result build-up
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_status_q <= ST_OK;
      res_ph_q     <= '0;
      res_pp_q     <= '0;
      res_mask_q   <= '0;
      res_freed_q  <= 1'b0;
      res_fh_q     <= '0;
    end
    if (cmd_i.eval) begin
      if (opcode_e'(op_q) == OP_PUT) begin
        if (hit_q)              res_status_q <= ST_DUP;
        else if (!free_found_q) res_status_q <= ST_FULL;
      end else if (!hit_q) begin
        res_status_q <= ST_NOTFOUND;
      end else if (rel_free) begin
        res_freed_q <= 1'b1;
        res_fh_q    <= hnd_q;
      end
    end
    if (cmd_i.bcast && !bend && bfull) begin
      res_mask_q <= res_mask_q | (MASK_W'(1) << cidx_q);
      if (tbl_valid_q[rel_idx] && rel_free) begin
        res_freed_q <= 1'b1;
        res_fh_q    <= hnd_q;
      end
    end
    if (cmd_i.pop && !pop_hit) res_status_q <= ST_EMPTY;
    if (cmd_i.popw) begin
      res_ph_q <= rdata_q[31:0];
      res_pp_q <= rdata_q[63:32];
    end
    if (cmd_i.emit) begin
      status_o         <= res_status_q;
      popped_handle_o  <= res_ph_q;
      popped_payload_o <= res_pp_q;
      dropped_mask_o   <= res_mask_q;
      freed_o          <= res_freed_q;
      freed_handle_o   <= res_fh_q;
    end
  end

endmodule

/* rtl/core/broadcast_fifo_with_buffer_release.sv */
// Top level of the broadcast FIFO with buffer release.
// Joins bfwbr_ctrl and bfwbr_dp; uses bfwbr_pkg.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_stall_o   opcode, consumer, buffer_handle, payload
//  out      output     out_valid_o/out_stall_i status, popped_*, dropped_mask, freed*
//  cfg      input      cfg_we_i                consumer_count (cfg_data_i)
//
// Put and release: table scan, one entry a cycle, ending at a match or the last entry;
// then for a put that takes a free entry, broadcast to one active consumer ring a cycle.
// Pop: a ring memory read into a register when the ring is not empty, then the result.
// One item at a time; the next is taken while the last result waits in the
// output register. Reset clears table, pointers and the output valid flag at once.
module broadcast_fifo_with_buffer_release #(
  parameter int unsigned CONSUMERS     = bfwbr_pkg::CONSUMERS_DEF,
  parameter int unsigned RING_DEPTH    = bfwbr_pkg::RING_DEPTH_DEF,
  parameter int unsigned TABLE_ENTRIES = bfwbr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  consumer_i,
  input  logic [31:0] buffer_handle_i,
  input  logic [31:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] popped_handle_o,
  output logic [31:0] popped_payload_o,
  output logic [7:0]  dropped_mask_o,
  output logic        freed_o,
  output logic [31:0] freed_handle_o
);
  import bfwbr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfwbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfwbr_dp #(
    .CONSUMERS     (CONSUMERS),
    .RING_DEPTH    (RING_DEPTH),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .consumer_i       (consumer_i),
    .buffer_handle_i  (buffer_handle_i),
    .payload_i        (payload_i),
    .status_o         (status_o),
    .popped_handle_o  (popped_handle_o),
    .popped_payload_o (popped_payload_o),
    .dropped_mask_o   (dropped_mask_o),
    .freed_o          (freed_o),
    .freed_handle_o   (freed_handle_o)
  );

endmodule

/* rtl/core/bfwbr_chk.sv */
// Port checker for the broadcast FIFO with buffer release.
// Uses assert_macros.svh and bfwbr_pkg; bound to the top level below.
`include "assert_macros.svh"

module bfwbr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] popped_handle_o,
  input logic [7:0]  dropped_mask_o,
  input logic        freed_o
);
  import bfwbr_pkg::*;

  `BFW_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `BFW_ASSERT(a_busy_after_transfer, in_valid_i && !in_stall_o |=> in_stall_o)
  `BFW_ASSERT_NEVER(a_freed_bad_status, out_valid_o && freed_o && status_o != ST_OK)
  `BFW_ASSERT_NEVER(a_pop_data_on_fail, out_valid_o && status_o != ST_OK && popped_handle_o != '0)
  `BFW_ASSERT_NEVER(a_mask_on_fail, out_valid_o && status_o != ST_OK && dropped_mask_o != '0)

endmodule

bind broadcast_fifo_with_buffer_release bfwbr_chk u_bfwbr_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .popped_handle_o (popped_handle_o),
  .dropped_mask_o  (dropped_mask_o),
  .freed_o         (freed_o)
);

/* verif/tb_broadcast_fifo_with_buffer_release.sv */
// Testbench for broadcast_fifo_with_buffer_release: directed and random transfers,
// each result checked against an in-bench predictor of rings and release table.
// Depends on bfwbr_pkg and the RTL top level only.
module tb_broadcast_fifo_with_buffer_release;
  import bfwbr_pkg::*;

  localparam int NCONS = 8;
  localparam int DEPTH = 16;
  localparam int NTAB  = 32;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    status_e     status;
    logic [31:0] popped_handle;
    logic [31:0] popped_payload;
    logic [7:0]  dropped_mask;
    logic        freed;
    logic [31:0] freed_handle;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] opcode_i = '0;
  logic [2:0] consumer_i = '0;
  logic [31:0] buffer_handle_i = '0;
  logic [31:0] payload_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [31:0] popped_handle_o, popped_payload_o, freed_handle_o;
  logic [7:0] dropped_mask_o;
  logic freed_o;

  broadcast_fifo_with_buffer_release dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [63:0] ring_mem [NCONS][DEPTH];
  logic [3:0]  rd_ptr [NCONS];
  logic [3:0]  wr_ptr [NCONS];
  logic [31:0] tab_handle [NTAB];
  logic [3:0]  tab_count [NTAB];
  logic        tab_valid [NTAB];
  logic [3:0]  consumer_count;

  result_t     expected_results [$];
  logic [31:0] live_handles [$];
  int  errors = 0;
  int  cycles = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;

  function automatic int active_rings();
    return (consumer_count > NCONS) ? NCONS : consumer_count;
  endfunction

  function automatic int lookup(logic [31:0] h);
    for (int i = 0; i < NTAB; i++)
      if (tab_valid[i] && tab_handle[i] == h) return i;
    return -1;
  endfunction

  function automatic bit count_release(int e);
    tab_count[e] = tab_count[e] + 4'd1;
    if (tab_count[e] >= active_rings() || tab_count[e] == 0) begin
      tab_valid[e] = 1'b0;
      tab_count[e] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_transfer(opcode_e op, logic [2:0] c,
                                               logic [31:0] h, logic [31:0] p);
    result_t r;
    int e;
    logic [3:0] nxt;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUT: begin
        if (lookup(h) >= 0) begin
          r.status = ST_DUP;
        end else begin
          e = -1;
          for (int i = 0; i < NTAB; i++)
            if (!tab_valid[i] && e < 0) e = i;
          if (e < 0) begin
            r.status = ST_FULL;
          end else begin
            tab_valid[e] = 1'b1;
            tab_handle[e] = h;
            tab_count[e] = '0;
            for (int k = 0; k < active_rings(); k++) begin
              nxt = wr_ptr[k] + 4'd1;
              if (nxt == rd_ptr[k]) begin
                r.dropped_mask[k] = 1'b1;
                if (tab_valid[e] && count_release(e)) begin
                  r.freed = 1'b1;
                  r.freed_handle = h;
                end
              end else begin
                ring_mem[k][wr_ptr[k]] = {p, h};
                wr_ptr[k] = nxt;
              end
            end
          end
        end
      end
      OP_POP: begin
        if (rd_ptr[c] == wr_ptr[c]) begin
          r.status = ST_EMPTY;
        end else begin
          {r.popped_payload, r.popped_handle} = ring_mem[c][rd_ptr[c]];
          rd_ptr[c] = rd_ptr[c] + 4'd1;
        end
      end
      OP_REL: begin
        e = lookup(h);
        if (e < 0) begin
          r.status = ST_NOTFOUND;
        end else if (count_release(e)) begin
          r.freed = 1'b1;
          r.freed_handle = h;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic send_transfer(opcode_e op, logic [2:0] c, logic [31:0] h,
                               logic [31:0] p);
    @(posedge clk_i);
    idle_burst();
    in_valid_i <= 1'b1;
    opcode_i <= op;
    consumer_i <= c;
    buffer_handle_i <= h;
    payload_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_transfer(op, c, h, p));
    in_valid_i <= 1'b0;
  endtask

  task automatic write_consumer_count(logic [3:0] v);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    consumer_count = v;
  endtask

  always @(posedge clk_i) begin
    if (quiet) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= (stall_left != 0);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8);
      out_stall_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t x;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation, status %0d", status_o);
        errors++;
      end else begin
        x = expected_results.pop_front();
        if (status_o !== x.status) begin
          $error("status exp %0d got %0d", x.status, status_o); errors++;
        end
        if (popped_handle_o !== x.popped_handle) begin
          $error("popped_handle exp %h got %h", x.popped_handle, popped_handle_o);
          errors++;
        end
        if (popped_payload_o !== x.popped_payload) begin
          $error("popped_payload exp %h got %h", x.popped_payload, popped_payload_o);
          errors++;
        end
        if (dropped_mask_o !== x.dropped_mask) begin
          $error("dropped_mask exp %h got %h", x.dropped_mask, dropped_mask_o);
          errors++;
        end
        if (freed_o !== x.freed) begin
          $error("freed exp %0d got %0d", x.freed, freed_o); errors++;
        end
        if (freed_handle_o !== x.freed_handle) begin
          $error("freed_handle exp %h got %h", x.freed_handle, freed_handle_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[broadcast_fifo_with_buffer_release] ERROR");
      $finish;
    end
  end

  task automatic test_extremes();
    send_transfer(OP_POP, 3'd0, '0, '0);
    send_transfer(OP_POP, 3'd7, '0, '0);
    send_transfer(OP_REL, 3'd0, 32'hFFFF_FFFF, '0);
    send_transfer(OP_PUT, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_transfer(OP_PUT, 3'd0, 32'hFFFF_FFFF, 32'h0);
    send_transfer(OP_PUT, 3'd0, 32'h0, 32'hA5A5_5A5A);
    send_transfer(OP_NOP, 3'd5, 32'h1234_5678, 32'h9ABC_DEF0);
    send_transfer(OP_POP, 3'd0, '0, '0);
    send_transfer(OP_POP, 3'd0, '0, '0);
    send_transfer(OP_REL, 3'd0, 32'hFFFF_FFFF, '0);
    send_transfer(OP_REL, 3'd0, 32'h0, '0);
  endtask

  task automatic test_ring_overflow();
    write_consumer_count(4'd2);
    for (int i = 0; i < 17; i++)
      send_transfer(OP_PUT, 3'd0, 32'h100 + i, $urandom);
    for (int i = 0; i < 16; i++)
      send_transfer(OP_POP, 3'(i % 2), '0, '0);
  endtask

  task automatic test_table_full();
    write_consumer_count(4'd0);
    for (int i = 0; i < 34; i++)
      send_transfer(OP_PUT, 3'd0, 32'h200 + i, $urandom);
    for (int i = 0; i < 33; i++)
      send_transfer(OP_REL, 3'd0, 32'h200 + i, '0);
  endtask

  task automatic test_random(int n);
    logic [31:0] h;
    int idx;
    opcode_e op;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: op = OP_PUT;
        3, 4, 5: op = OP_POP;
        9: op = opcode_e'($urandom_range(0, 3));
        default: op = OP_REL;
      endcase
      if (op == OP_PUT && live_handles.size() > 0 && $urandom_range(0, 9) == 0)
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      else if (op == OP_PUT)
        h = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 63);
      else if (op == OP_REL && live_handles.size() > 0 && $urandom_range(0, 7) != 0) begin
        idx = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[idx];
      end else
        h = $urandom;
      if (op == OP_PUT) live_handles.push_back(h);
      if (live_handles.size() > 64) void'(live_handles.pop_front());
      send_transfer(op, 3'($urandom), h, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < NCONS; i++) begin
      rd_ptr[i] = '0;
      wr_ptr[i] = '0;
    end
    for (int i = 0; i < NTAB; i++) begin
      tab_valid[i] = 1'b0;
      tab_count[i] = '0;
      tab_handle[i] = '0;
    end
    consumer_count = 4'd1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_ring_overflow();
    test_table_full();
    write_consumer_count(4'd8);
    test_random(400);
    write_consumer_count(4'd15);
    test_random(300);
    write_consumer_count(4'd1);
    test_random(400);
    write_consumer_count(4'd3);
    test_random(400);
    write_consumer_count(4'd0);
    test_random(100);
    write_consumer_count(4'd5);
    quiet = 1'b1;
    test_random(300);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0)
      $display("[broadcast_fifo_with_buffer_release] OK");
    else
      $display("[broadcast_fifo_with_buffer_release] ERROR");
    $finish;
  end
endmodule
